// ----- src/wom_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wom_pkg: shared types and constants for the waypoint obstacle mover
// Opcodes, reply kinds, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package wom_pkg;

   localparam int COORD_W   = 16;
   localparam int LEN_W     = 5;
   localparam int STEP_W    = 12;
   localparam int MUL_W     = 17;
   localparam int PROD_W    = 34;
   localparam int DVD_W     = 28;
   localparam int RES_CNT_W = 4;

   // at most this many position reports per tick
   localparam logic [RES_CNT_W-1:0] RES_MAX = 4'd8;

   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_ADD   = 3'd2;
   localparam logic [2:0] OP_TICK  = 3'd3;
   localparam logic [2:0] OP_QUERY = 3'd4;

   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_POS     = 2'd1;
   localparam logic [1:0] KIND_QUERY   = 2'd2;
   localparam logic [1:0] KIND_REFUSED = 2'd3;

   localparam logic CSR_REACH  = 1'b0;
   localparam logic CSR_RADIUS = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ADD_LOAD,
      ST_EMIT,
      ST_T_SCAN,
      ST_T_DIST,
      ST_T_SQX,
      ST_T_SQY,
      ST_T_REACH,
      ST_T_CMP,
      ST_T_STEP,
      ST_T_OVER,
      ST_T_SQRT,
      ST_T_MUL,
      ST_T_DIVLD,
      ST_T_DIV,
      ST_T_UPD,
      ST_Q_LIM,
      ST_Q_SCAN,
      ST_Q_CMP
   } state_type;

endpackage

// ----- src/wom_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wom_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wom_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/waypoint_obstacle_mover.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_obstacle_mover: table of obstacles that walk waypoint paths
// Sequencer around one shared multiplier, a bit-serial square root and a
// bit-serial divider; waypoints live in a RAM, robot state in registers.
// ----------------------------------------------------------------------------
// The block takes one request at a time and holds req_stall high until the
// request is fully worked off; the last reply of each request carries
// rsp_last_reply. A query passes each active robot through the shared 17x17
// multiplier, one pass per square. A tick walks the robot table in slot order:
// an inactive slot is skipped, a robot that reaches or overshoots its target
// is snapped onto it, and a robot that moves part of the way runs the 17-step
// square root and the two 28-step divisions that scale the step onto x and y.
// Every reply also waits for the result register to drain when rsp_stall is
// high. Waypoints written never need clearing; reset and clear drop the
// active flags and leave the waypoint RAM as it is.
// ----------------------------------------------------------------------------
module waypoint_obstacle_mover #(
   parameter int MAX_ROBOTS = 8,
   parameter int MAX_POINTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [2:0]  req_robot_slot,
   input  logic [3:0]  req_point_index,
   input  logic [15:0] req_coord_x,
   input  logic [15:0] req_coord_y,
   input  logic [15:0] req_robot_speed,
   input  logic [4:0]  req_path_length,
   input  logic [15:0] req_delta_time,
   input  logic [15:0] req_probe_radius,
   // reply channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_reply_kind,
   output logic [2:0]  rsp_out_slot,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic        rsp_near_hit,
   output logic        rsp_last_reply,
   // register writes
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int RIDX_W   = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;
   localparam int RCNT_W   = $clog2(MAX_ROBOTS + 1);
   localparam int NODE_W   = $clog2(MAX_POINTS);
   localparam int WP_DEPTH = MAX_ROBOTS * MAX_POINTS;
   localparam int WP_AW    = $clog2(WP_DEPTH);
   localparam int CW       = wom_pkg::COORD_W;
   localparam int MW       = wom_pkg::MUL_W;
   localparam int PW       = wom_pkg::PROD_W;
   localparam int DW       = wom_pkg::DVD_W;

   // ---------------------------------------------------------------- state
   wom_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   // latched request
   logic [2:0]      op_ff, slot_ff;
   logic [3:0]      pidx_ff;
   logic [CW-1:0]   cx_ff, cy_ff, spd_ff, dt_ff, probe_ff;
   logic [wom_pkg::LEN_W-1:0] plen_ff;

   // configuration
   logic [CW-1:0]   reach_ff, radius_ff;

   // robot table
   logic [MAX_ROBOTS-1:0]     active_ff;
   logic [CW-1:0]             pos_x_ff [MAX_ROBOTS];
   logic [CW-1:0]             pos_y_ff [MAX_ROBOTS];
   logic [CW-1:0]             speed_ff [MAX_ROBOTS];
   logic [NODE_W-1:0]         cur_ff   [MAX_ROBOTS];
   logic [NODE_W-1:0]         prev_ff  [MAX_ROBOTS];
   logic [NODE_W-1:0]         tgt_ff   [MAX_ROBOTS];
   logic [wom_pkg::LEN_W-1:0] len_ff   [MAX_ROBOTS];

   // sequencer datapath
   logic [RCNT_W-1:0]            r_ff, r_in;
   logic [wom_pkg::RES_CNT_W-1:0] n_ff, n_in;
   logic [CW-1:0]  tx_ff, tx_in, ty_ff, ty_in, dx_ff, dx_in, dy_ff, dy_in;
   logic           xup_ff, xup_in, yup_ff, yup_in;
   logic [PW-1:0]  dist2_ff, dist2_in, lim_ff, lim_in;
   logic [wom_pkg::STEP_W-1:0] step_ff, step_in;
   logic [PW-1:0]  sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [MW-1:0]  d_ff, d_in, rem_ff, rem_in;
   logic [DW-1:0]  dvd_ff, dvd_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic [CW-1:0]  qx_ff, qx_in;
   logic           phase_ff, phase_in, hit_ff, hit_in;

   // shared multiplier
   logic [MW-1:0]  mul_a, mul_b;
   logic [PW-1:0]  prod_ff;

   // pending reply
   logic [1:0]     res_kind_ff, res_kind_in;
   logic [2:0]     res_slot_ff, res_slot_in;
   logic [CW-1:0]  res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic           res_hit_ff, res_hit_in, res_last_ff, res_last_in;

   // reply register
   logic           rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [1:0]     rsp_kind_ff;
   logic [2:0]     rsp_slot_ff;
   logic [CW-1:0]  rsp_x_ff, rsp_y_ff;
   logic           rsp_hit_ff, rsp_last_ff;

   // table write controls
   logic           clear_en, add_en, pos_we, node_we;
   logic [CW-1:0]  pos_wx, pos_wy;
   logic [NODE_W-1:0] ncur, nprev, ntgt;

   // waypoint RAM
   logic             ram_we;
   logic [WP_AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]      ram_wdata, ram_rdata;

   // helpers
   logic [RIDX_W-1:0] ridx, add_idx;
   logic [CW-1:0]     px, py, nx, ny;
   logic              higher, rsp_free, accept;
   logic [PW-1:0]     sq_sum;
   logic [MW:0]       trial;
   logic [DW-1:0]     dvd_next;
   logic [8:0]        c9, len9;
   logic              lo, hi;

   // emit request from the sequencer
   logic           em_go, em_last, em_hit;
   logic [1:0]     em_kind;
   logic [2:0]     em_slot;
   logic [CW-1:0]  em_x, em_y;
   logic           rep_go;
   logic [CW-1:0]  rep_x, rep_y;

   assign ridx     = r_ff[RIDX_W-1:0];
   assign add_idx  = RIDX_W'(slot_ff);
   assign px       = pos_x_ff[ridx];
   assign py       = pos_y_ff[ridx];
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != wom_pkg::ST_IDLE);

   // any active robot after the current slot (decides the final report)
   always_comb begin
      higher = 1'b0;
      for (int i = 0; i < MAX_ROBOTS; i++) begin
         if (active_ff[i] && (i > int'(r_ff))) begin
            higher = 1'b1;
         end
      end
   end

   // next target after a waypoint is reached: no backtracking but at a path end
   always_comb begin
      ncur  = tgt_ff[ridx];
      nprev = cur_ff[ridx];
      c9    = 9'(ncur);
      len9  = 9'(len_ff[ridx]);
      lo    = (ncur != '0);
      hi    = ((c9 + 9'd1) < len9);
      if (len9 < 9'd2) begin
         ntgt = ncur;
      end else if (lo && hi) begin
         ntgt = ((c9 + 9'd1) != 9'(nprev)) ? NODE_W'(c9 + 9'd1) : NODE_W'(c9 - 9'd1);
      end else if (hi) begin
         ntgt = NODE_W'(c9 + 9'd1);
      end else if (lo) begin
         ntgt = NODE_W'(c9 - 9'd1);
      end else begin
         ntgt = ncur;
      end
   end

   // serial arithmetic steps
   assign sq_sum   = sq_r_ff + sq_bit_ff;
   assign trial    = {rem_ff, dvd_ff[DW-1]};
   assign dvd_next = {dvd_ff[DW-2:0], (trial >= {1'b0, d_ff})};
   assign nx = xup_ff ? (px + qx_ff) : (px - qx_ff);
   assign ny = yup_ff ? (py + dvd_ff[CW-1:0]) : (py - dvd_ff[CW-1:0]);

   // ---------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      r_in = r_ff;   n_in = n_ff;
      tx_in = tx_ff; ty_in = ty_ff; dx_in = dx_ff; dy_in = dy_ff;
      xup_in = xup_ff; yup_in = yup_ff;
      dist2_in = dist2_ff; lim_in = lim_ff; step_in = step_ff;
      sq_v_in = sq_v_ff; sq_r_in = sq_r_ff; sq_bit_in = sq_bit_ff;
      d_in = d_ff; rem_in = rem_ff; dvd_in = dvd_ff; cnt_in = cnt_ff;
      qx_in = qx_ff; phase_in = phase_ff; hit_in = hit_ff;
      res_kind_in = res_kind_ff; res_slot_in = res_slot_ff;
      res_x_in = res_x_ff; res_y_in = res_y_ff;
      res_hit_in = res_hit_ff; res_last_in = res_last_ff;
      mul_a = '0; mul_b = '0;
      clear_en = 1'b0; add_en = 1'b0; pos_we = 1'b0; node_we = 1'b0;
      pos_wx = tx_ff; pos_wy = ty_ff;
      ram_we = 1'b0;
      ram_waddr = WP_AW'(slot_ff) * WP_AW'(MAX_POINTS) + WP_AW'(pidx_ff);
      ram_wdata = {cy_ff, cx_ff};
      ram_raddr = WP_AW'(ridx) * WP_AW'(MAX_POINTS) + WP_AW'(tgt_ff[ridx]);
      em_go = 1'b0; em_kind = wom_pkg::KIND_ACK; em_slot = '0;
      em_x = '0; em_y = '0; em_hit = 1'b0; em_last = 1'b1;
      rep_go = 1'b0; rep_x = tx_ff; rep_y = ty_ff;
      rsp_load = 1'b0;

      unique case (state_ff)
         wom_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = wom_pkg::ST_DISPATCH;
            end
         end

         wom_pkg::ST_DISPATCH: begin
            unique case (op_ff)
               wom_pkg::OP_CLEAR: begin
                  clear_en = 1'b1;
                  em_go    = 1'b1;
               end
               wom_pkg::OP_WRITE: begin
                  ram_we = (32'(slot_ff) < MAX_ROBOTS) && (32'(pidx_ff) < MAX_POINTS);
                  em_go  = 1'b1;
               end
               wom_pkg::OP_ADD: begin
                  if ((32'(slot_ff) < MAX_ROBOTS) && (plen_ff >= 5'd2) &&
                      (32'(plen_ff) <= MAX_POINTS)) begin
                     // fetch waypoint 0 of the slot
                     ram_raddr = WP_AW'(slot_ff) * WP_AW'(MAX_POINTS);
                     state_in  = wom_pkg::ST_ADD_LOAD;
                  end else begin
                     em_go   = 1'b1;
                     em_kind = wom_pkg::KIND_REFUSED;
                  end
               end
               wom_pkg::OP_TICK: begin
                  r_in     = '0;
                  n_in     = '0;
                  state_in = wom_pkg::ST_T_SCAN;
               end
               wom_pkg::OP_QUERY: begin
                  mul_a    = MW'(probe_ff) + MW'(radius_ff);
                  mul_b    = MW'(probe_ff) + MW'(radius_ff);
                  state_in = wom_pkg::ST_Q_LIM;
               end
               default: begin
                  em_go = 1'b1;
               end
            endcase
         end

         wom_pkg::ST_ADD_LOAD: begin
            add_en = 1'b1;
            em_go  = 1'b1;
         end

         wom_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = res_last_ff ? wom_pkg::ST_IDLE : ret_ff;
            end
         end

         // tick: walk the table in slot order
         wom_pkg::ST_T_SCAN: begin
            if (r_ff == RCNT_W'(MAX_ROBOTS)) begin
               if (n_ff == '0) begin
                  em_go = 1'b1;
               end else begin
                  state_in = wom_pkg::ST_IDLE;
               end
            end else if (!active_ff[ridx]) begin
               r_in = r_ff + 1'b1;
            end else begin
               state_in = wom_pkg::ST_T_DIST;
            end
         end

         wom_pkg::ST_T_DIST: begin
            tx_in  = ram_rdata[CW-1:0];
            ty_in  = ram_rdata[31:CW];
            xup_in = (ram_rdata[CW-1:0] >= px);
            yup_in = (ram_rdata[31:CW] >= py);
            dx_in  = (ram_rdata[CW-1:0] >= px) ? (ram_rdata[CW-1:0] - px)
                                                : (px - ram_rdata[CW-1:0]);
            dy_in  = (ram_rdata[31:CW] >= py) ? (ram_rdata[31:CW] - py)
                                               : (py - ram_rdata[31:CW]);
            state_in = wom_pkg::ST_T_SQX;
         end

         wom_pkg::ST_T_SQX: begin
            mul_a    = MW'(dx_ff);
            mul_b    = MW'(dx_ff);
            state_in = wom_pkg::ST_T_SQY;
         end

         wom_pkg::ST_T_SQY: begin
            dist2_in = prod_ff;
            mul_a    = MW'(dy_ff);
            mul_b    = MW'(dy_ff);
            state_in = wom_pkg::ST_T_REACH;
         end

         wom_pkg::ST_T_REACH: begin
            dist2_in = dist2_ff + prod_ff;
            mul_a    = MW'(reach_ff);
            mul_b    = MW'(reach_ff);
            state_in = (op_ff == wom_pkg::OP_QUERY) ? wom_pkg::ST_Q_CMP : wom_pkg::ST_T_CMP;
         end

         wom_pkg::ST_T_CMP: begin
            if (dist2_ff <= prod_ff) begin
               // reached: snap and advance along the path
               pos_we  = 1'b1;
               node_we = 1'b1;
               rep_go  = 1'b1;
            end else begin
               mul_a    = MW'(speed_ff[ridx]);
               mul_b    = MW'(dt_ff);
               state_in = wom_pkg::ST_T_STEP;
            end
         end

         wom_pkg::ST_T_STEP: begin
            step_in  = prod_ff[31:20];
            mul_a    = MW'(prod_ff[31:20]);
            mul_b    = MW'(prod_ff[31:20]);
            state_in = wom_pkg::ST_T_OVER;
         end

         wom_pkg::ST_T_OVER: begin
            if (prod_ff >= dist2_ff) begin
               // overshoot: snap without advancing
               pos_we = 1'b1;
               rep_go = 1'b1;
            end else begin
               sq_v_in   = dist2_ff;
               sq_r_in   = '0;
               sq_bit_in = PW'(1) << (PW - 2);
               state_in  = wom_pkg::ST_T_SQRT;
            end
         end

         wom_pkg::ST_T_SQRT: begin
            if (sq_v_ff >= sq_sum) begin
               sq_v_in = sq_v_ff - sq_sum;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               phase_in = 1'b0;
               state_in = wom_pkg::ST_T_MUL;
            end
         end

         wom_pkg::ST_T_MUL: begin
            d_in     = (sq_r_ff == '0) ? MW'(1) : sq_r_ff[MW-1:0];
            mul_a    = phase_ff ? MW'(dy_ff) : MW'(dx_ff);
            mul_b    = MW'(step_ff);
            state_in = wom_pkg::ST_T_DIVLD;
         end

         wom_pkg::ST_T_DIVLD: begin
            dvd_in   = prod_ff[DW-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = wom_pkg::ST_T_DIV;
         end

         wom_pkg::ST_T_DIV: begin
            rem_in = (trial >= {1'b0, d_ff}) ? MW'(trial - {1'b0, d_ff}) : trial[MW-1:0];
            dvd_in = dvd_next;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DW - 1)) begin
               if (!phase_ff) begin
                  qx_in    = dvd_next[CW-1:0];
                  phase_in = 1'b1;
                  state_in = wom_pkg::ST_T_MUL;
               end else begin
                  state_in = wom_pkg::ST_T_UPD;
               end
            end
         end

         wom_pkg::ST_T_UPD: begin
            pos_we = 1'b1;
            pos_wx = nx;
            pos_wy = ny;
            rep_go = 1'b1;
            rep_x  = nx;
            rep_y  = ny;
         end

         // query: compare every active robot against the probe circle
         wom_pkg::ST_Q_LIM: begin
            lim_in   = prod_ff;
            r_in     = '0;
            hit_in   = 1'b0;
            state_in = wom_pkg::ST_Q_SCAN;
         end

         wom_pkg::ST_Q_SCAN: begin
            if (r_ff == RCNT_W'(MAX_ROBOTS)) begin
               em_go   = 1'b1;
               em_kind = wom_pkg::KIND_QUERY;
               em_hit  = hit_ff;
            end else if (!active_ff[ridx]) begin
               r_in = r_ff + 1'b1;
            end else begin
               dx_in    = (cx_ff >= px) ? (cx_ff - px) : (px - cx_ff);
               dy_in    = (cy_ff >= py) ? (cy_ff - py) : (py - cy_ff);
               state_in = wom_pkg::ST_T_SQX;
            end
         end

         wom_pkg::ST_Q_CMP: begin
            if (dist2_ff <= lim_ff) begin
               hit_in = 1'b1;
            end
            r_in     = r_ff + 1'b1;
            state_in = wom_pkg::ST_Q_SCAN;
         end

         default: begin
            state_in = wom_pkg::ST_IDLE;
         end
      endcase

      // position report after one robot has moved
      if (rep_go) begin
         r_in = r_ff + 1'b1;
         if (n_ff < wom_pkg::RES_MAX) begin
            n_in    = n_ff + 1'b1;
            em_go   = 1'b1;
            em_kind = wom_pkg::KIND_POS;
            em_slot = 3'(r_ff);
            em_x    = rep_x;
            em_y    = rep_y;
            em_last = (n_ff == wom_pkg::RES_MAX - 1'b1) || !higher;
         end else begin
            state_in = wom_pkg::ST_T_SCAN;
         end
      end

      if (em_go) begin
         res_kind_in = em_kind;
         res_slot_in = em_slot;
         res_x_in    = em_x;
         res_y_in    = em_y;
         res_hit_in  = em_hit;
         res_last_in = em_last;
         ret_in      = wom_pkg::ST_T_SCAN;
         state_in    = wom_pkg::ST_EMIT;
      end

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wom_pkg::ST_IDLE;
         ret_ff       <= wom_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
         reach_ff     <= 16'd32;
         radius_ff    <= 16'd224;
         r_ff         <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         r_ff         <= r_in;
         n_ff         <= n_in;
         if (csr_wr_en) begin
            unique case (csr_addr)
               wom_pkg::CSR_REACH:  reach_ff  <= csr_wdata;
               wom_pkg::CSR_RADIUS: radius_ff <= csr_wdata;
               default: ;
            endcase
         end
         // drop every robot on clear
         if (clear_en) begin
            active_ff <= '0;
         end else if (add_en) begin
            active_ff[add_idx] <= 1'b1;
         end
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         slot_ff  <= req_robot_slot;
         pidx_ff  <= req_point_index;
         cx_ff    <= req_coord_x;
         cy_ff    <= req_coord_y;
         spd_ff   <= req_robot_speed;
         plen_ff  <= req_path_length;
         dt_ff    <= req_delta_time;
         probe_ff <= req_probe_radius;
      end
      prod_ff   <= mul_a * mul_b;
      tx_ff     <= tx_in;
      ty_ff     <= ty_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      xup_ff    <= xup_in;
      yup_ff    <= yup_in;
      dist2_ff  <= dist2_in;
      lim_ff    <= lim_in;
      step_ff   <= step_in;
      sq_v_ff   <= sq_v_in;
      sq_r_ff   <= sq_r_in;
      sq_bit_ff <= sq_bit_in;
      d_ff      <= d_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      cnt_ff    <= cnt_in;
      qx_ff     <= qx_in;
      phase_ff  <= phase_in;
      hit_ff    <= hit_in;
      res_kind_ff <= res_kind_in;
      res_slot_ff <= res_slot_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_hit_ff  <= res_hit_in;
      res_last_ff <= res_last_in;
      if (rsp_load) begin
         rsp_kind_ff <= res_kind_ff;
         rsp_slot_ff <= res_slot_ff;
         rsp_x_ff    <= res_x_ff;
         rsp_y_ff    <= res_y_ff;
         rsp_hit_ff  <= res_hit_ff;
         rsp_last_ff <= res_last_ff;
      end
      // activate: start at waypoint 0 heading for node 1
      if (add_en) begin
         pos_x_ff[add_idx] <= ram_rdata[CW-1:0];
         pos_y_ff[add_idx] <= ram_rdata[31:CW];
         speed_ff[add_idx] <= spd_ff;
         cur_ff[add_idx]   <= '0;
         prev_ff[add_idx]  <= '0;
         tgt_ff[add_idx]   <= NODE_W'(1);
         len_ff[add_idx]   <= plen_ff;
      end
      if (pos_we) begin
         pos_x_ff[ridx] <= pos_wx;
         pos_y_ff[ridx] <= pos_wy;
      end
      if (node_we) begin
         prev_ff[ridx] <= nprev;
         cur_ff[ridx]  <= ncur;
         tgt_ff[ridx]  <= ntgt;
      end
   end

   wom_ram #(
      .WIDTH (32),
      .DEPTH (WP_DEPTH)
   ) u_waypoints (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply_kind = rsp_kind_ff;
   assign rsp_out_slot   = rsp_slot_ff;
   assign rsp_pos_x      = rsp_x_ff;
   assign rsp_pos_y      = rsp_y_ff;
   assign rsp_near_hit   = rsp_hit_ff;
   assign rsp_last_reply = rsp_last_ff;

   // ----------------------------------------------------------- assertions
   a_sqrt_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wom_pkg::ST_T_SQRT) |-> $onehot(sq_bit_ff))
      else $error("square root bit lost its single set bit");

   a_report_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= wom_pkg::RES_MAX)
      else $error("tick reported more robots than allowed");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == wom_pkg::ST_DISPATCH))
      else $error("accepted request did not reach dispatch");

endmodule
